/* design/mfp_pkg.sv */
// Shared types and constants for the motor feedback frame parser.
// No dependencies; every other design file refers to this package by scoped names.
package mfp_pkg;

  localparam logic [7:0] HEADER_BYTE = 8'h7A;
  localparam logic [7:0] TAIL_BYTE   = 8'h7B;

  // Frame byte positions (header is position 0, tail is position 8)
  localparam int unsigned POS_W   = 4;
  localparam logic [POS_W-1:0] POS_IDLE = 4'd0;
  localparam logic [POS_W-1:0] POS_ADDR = 4'd1;
  localparam logic [POS_W-1:0] POS_TYPE = 4'd2;
  localparam logic [POS_W-1:0] POS_BCC  = 4'd7;
  localparam logic [POS_W-1:0] POS_TAIL = 4'd8;
  // Bytes at positions below this one enter the running XOR
  localparam logic [POS_W-1:0] XOR_LEN  = 4'd7;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 4;
  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_ADDR  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SECOND_ADDR = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ANGLE_TYPE  = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_TYPE  = 4'd3;

  typedef enum logic [1:0] {
    ST_GOOD      = 2'd0,
    ST_BAD_TAIL  = 2'd1,
    ST_BAD_CHECK = 2'd2
  } frame_status_t;

  // Completed frame, classified by the front end
  typedef struct packed {
    frame_status_t status;
    logic [7:0]    addr;
    logic [7:0]    ftype;
    logic [31:0]   value;
    logic [31:0]   headers;
  } frame_rec_t;

  typedef struct packed {
    logic [7:0] first_addr;
    logic [7:0] second_addr;
    logic [7:0] angle_type;
    logic [7:0] speed_type;
  } cfg_t;

endpackage

/* design/mfp_front.sv */
// Byte front end: header hunt, frame assembly, running XOR and frame classification.
// Depends on mfp_pkg; pushes one frame_rec_t per completed frame.
module mfp_front #(
  parameter int COUNT_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               byte_fire,
  input  logic [7:0]         rx_byte,
  output logic               push,
  output mfp_pkg::frame_rec_t push_rec
);

  logic [mfp_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]                xor_r, xor_nxt;
  logic [7:0]                addr_r, addr_nxt;
  logic [7:0]                type_r, type_nxt;
  logic [7:0]                bcc_r, bcc_nxt;
  logic [31:0]               value_r, value_nxt;
  logic [COUNT_BITS-1:0]     hdr_r, hdr_nxt;

  always_comb begin
    pos_nxt   = pos_r;
    xor_nxt   = xor_r;
    addr_nxt  = addr_r;
    type_nxt  = type_r;
    bcc_nxt   = bcc_r;
    value_nxt = value_r;
    hdr_nxt   = hdr_r;
    push      = 1'b0;
    if (byte_fire) begin
      if (pos_r == mfp_pkg::POS_IDLE) begin
        if (rx_byte == mfp_pkg::HEADER_BYTE) begin
          hdr_nxt = hdr_r + COUNT_BITS'(1);
          xor_nxt = mfp_pkg::HEADER_BYTE;
          pos_nxt = mfp_pkg::POS_ADDR;
        end
      end else begin
        pos_nxt = pos_r + mfp_pkg::POS_W'(1);
        if (pos_r < mfp_pkg::XOR_LEN) begin
          xor_nxt = xor_r ^ rx_byte;
        end
        case (pos_r)
          mfp_pkg::POS_ADDR: addr_nxt = rx_byte;
          mfp_pkg::POS_TYPE: type_nxt = rx_byte;
          mfp_pkg::POS_BCC:  bcc_nxt  = rx_byte;
          mfp_pkg::POS_TAIL: begin
            push    = 1'b1;
            pos_nxt = mfp_pkg::POS_IDLE;
          end
          default: value_nxt = {value_r[23:0], rx_byte};
        endcase
      end
    end
  end

  // Tail is checked before the XOR
  always_comb begin
    if (rx_byte != mfp_pkg::TAIL_BYTE) begin
      push_rec.status = mfp_pkg::ST_BAD_TAIL;
    end else if (xor_r != bcc_r) begin
      push_rec.status = mfp_pkg::ST_BAD_CHECK;
    end else begin
      push_rec.status = mfp_pkg::ST_GOOD;
    end
    push_rec.addr    = addr_r;
    push_rec.ftype   = type_r;
    push_rec.value   = value_r;
    push_rec.headers = 32'(hdr_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= mfp_pkg::POS_IDLE;
      xor_r <= '0;
      hdr_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      xor_r <= xor_nxt;
      hdr_r <= hdr_nxt;
    end
    addr_r  <= addr_nxt;
    type_r  <= type_nxt;
    bcc_r   <= bcc_nxt;
    value_r <= value_nxt;
  end

endmodule

/* design/mfp_queue.sv */
// Short register queue of classified frames between front end and back end.
// Depends on mfp_pkg for the frame_rec_t entry type.
module mfp_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mfp_pkg::frame_rec_t push_rec,
  output logic                full,
  input  logic                pop,
  output logic                avail,
  output mfp_pkg::frame_rec_t pop_rec
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mfp_pkg::frame_rec_t   entries_r [DEPTH];
  logic [PTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]      count_r;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign avail   = (count_r != '0);
  assign pop_rec = entries_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] bump_ptr(input logic [PTR_W-1:0] p);
    bump_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= bump_ptr(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= bump_ptr(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
    if (push) begin
      entries_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

/* design/mfp_back.sv */
// Back end: motor value updates, error/good counters and the registered result stage.
// Depends on mfp_pkg; takes frames from mfp_queue and configuration from the top level.
module mfp_back #(
  parameter int COUNT_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mfp_pkg::cfg_t       cfg,
  input  logic                avail,
  input  mfp_pkg::frame_rec_t rec,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          frame_status,
  output logic [7:0]          frame_address,
  output logic [7:0]          frame_type,
  output logic [31:0]         frame_value,
  output logic [31:0]         motor_one_position,
  output logic [31:0]         motor_one_speed,
  output logic [31:0]         motor_two_position,
  output logic [31:0]         motor_two_speed,
  output logic [31:0]         headers_seen,
  output logic [31:0]         tail_errors,
  output logic [31:0]         check_errors,
  output logic [31:0]         good_frames
);

  logic                  valid_r;
  logic [31:0]           m1_pos_r, m1_pos_nxt;
  logic [31:0]           m1_spd_r, m1_spd_nxt;
  logic [31:0]           m2_pos_r, m2_pos_nxt;
  logic [31:0]           m2_spd_r, m2_spd_nxt;
  logic [COUNT_BITS-1:0] tail_cnt_r, tail_cnt_nxt;
  logic [COUNT_BITS-1:0] check_cnt_r, check_cnt_nxt;
  logic [COUNT_BITS-1:0] good_cnt_r, good_cnt_nxt;
  logic [1:0]            status_r;
  logic [7:0]            addr_r, type_r;
  logic [31:0]           value_r, headers_r;
  logic                  is_angle, is_speed;

  // Take a frame when the result register is empty or being drained
  assign pop = avail && (!valid_r || !out_stall);

  assign is_angle = (rec.ftype == cfg.angle_type);
  assign is_speed = !is_angle && (rec.ftype == cfg.speed_type);

  always_comb begin
    m1_pos_nxt    = m1_pos_r;
    m1_spd_nxt    = m1_spd_r;
    m2_pos_nxt    = m2_pos_r;
    m2_spd_nxt    = m2_spd_r;
    tail_cnt_nxt  = tail_cnt_r;
    check_cnt_nxt = check_cnt_r;
    good_cnt_nxt  = good_cnt_r;
    case (rec.status)
      mfp_pkg::ST_BAD_TAIL:  tail_cnt_nxt  = tail_cnt_r + COUNT_BITS'(1);
      mfp_pkg::ST_BAD_CHECK: check_cnt_nxt = check_cnt_r + COUNT_BITS'(1);
      mfp_pkg::ST_GOOD: begin
        good_cnt_nxt = good_cnt_r + COUNT_BITS'(1);
        // Motor one wins when both addresses match
        if (rec.addr == cfg.first_addr) begin
          if (is_angle) m1_pos_nxt = rec.value;
          if (is_speed) m1_spd_nxt = rec.value;
        end else if (rec.addr == cfg.second_addr) begin
          if (is_angle) m2_pos_nxt = rec.value;
          if (is_speed) m2_spd_nxt = rec.value;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      m1_pos_r    <= '0;
      m1_spd_r    <= '0;
      m2_pos_r    <= '0;
      m2_spd_r    <= '0;
      tail_cnt_r  <= '0;
      check_cnt_r <= '0;
      good_cnt_r  <= '0;
    end else begin
      if (pop) begin
        valid_r     <= 1'b1;
        m1_pos_r    <= m1_pos_nxt;
        m1_spd_r    <= m1_spd_nxt;
        m2_pos_r    <= m2_pos_nxt;
        m2_spd_r    <= m2_spd_nxt;
        tail_cnt_r  <= tail_cnt_nxt;
        check_cnt_r <= check_cnt_nxt;
        good_cnt_r  <= good_cnt_nxt;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
    if (pop) begin
      status_r  <= rec.status;
      addr_r    <= rec.addr;
      type_r    <= rec.ftype;
      value_r   <= rec.value;
      headers_r <= rec.headers;
    end
  end

  assign out_valid          = valid_r;
  assign frame_status       = status_r;
  assign frame_address      = addr_r;
  assign frame_type         = type_r;
  assign frame_value        = value_r;
  assign motor_one_position = m1_pos_r;
  assign motor_one_speed    = m1_spd_r;
  assign motor_two_position = m2_pos_r;
  assign motor_two_speed    = m2_spd_r;
  assign headers_seen       = headers_r;
  assign tail_errors        = 32'(tail_cnt_r);
  assign check_errors       = 32'(check_cnt_r);
  assign good_frames        = 32'(good_cnt_r);

endmodule

/* design/motor_feedback_frame_parser.sv */
// Top level of the motor feedback frame parser: configuration registers and module wiring.
// Depends on mfp_pkg, mfp_front, mfp_queue and mfp_back.
//
// Takes one received serial byte per transfer and assembles nine-byte frames
// (header 0x7A, address, type, 4-byte big-endian signed value, XOR check byte,
// tail 0x7B). Bytes outside a frame that are not the header are dropped; a
// header byte inside a frame is ordinary data. Every completed frame gives one
// result transfer carrying its status (good, bad tail, check mismatch), its
// address, type and value, the four stored motor values and the four wrapping
// counters. The block takes one byte per clock cycle while in_stall is low. The
// front end classifies the frame as its tail byte arrives and pushes it into a
// QUEUE_DEPTH-entry queue; the back end applies the motor update and counters
// and registers the result after the frame has passed through the queue.
// in_stall rises only while the queue is full, which needs several frames
// waiting behind a stalled result channel. Configuration writes take effect on
// the next frame processed and are meant to be made while the block is idle;
// register indexes beyond the four defined ones are ignored.
module motor_feedback_frame_parser #(
  parameter int COUNT_BITS  = 32,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mfp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [7:0]                          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_rx_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_frame_status,
  output logic [7:0]                          out_frame_address,
  output logic [7:0]                          out_frame_type,
  output logic signed [31:0]                  out_frame_value,
  output logic signed [31:0]                  out_motor_one_position,
  output logic signed [31:0]                  out_motor_one_speed,
  output logic signed [31:0]                  out_motor_two_position,
  output logic signed [31:0]                  out_motor_two_speed,
  output logic [31:0]                         out_headers_seen,
  output logic [31:0]                         out_tail_errors,
  output logic [31:0]                         out_check_errors,
  output logic [31:0]                         out_good_frames
);

  mfp_pkg::cfg_t       cfg_r;
  mfp_pkg::frame_rec_t push_rec, pop_rec;
  logic                push, pop, q_full, q_avail, byte_fire;

  // Configuration registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_addr  <= 8'd1;
      cfg_r.second_addr <= 8'd2;
      cfg_r.angle_type  <= 8'd1;
      cfg_r.speed_type  <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        mfp_pkg::CFG_FIRST_ADDR:  cfg_r.first_addr  <= cfg_wdata;
        mfp_pkg::CFG_SECOND_ADDR: cfg_r.second_addr <= cfg_wdata;
        mfp_pkg::CFG_ANGLE_TYPE:  cfg_r.angle_type  <= cfg_wdata;
        mfp_pkg::CFG_SPEED_TYPE:  cfg_r.speed_type  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Hold bytes only while the frame queue has no room
  assign in_stall  = q_full;
  assign byte_fire = in_valid && !in_stall;

  mfp_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_fire(byte_fire),
    .rx_byte  (in_rx_byte),
    .push     (push),
    .push_rec (push_rec)
  );

  mfp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_rec(push_rec),
    .full    (q_full),
    .pop     (pop),
    .avail   (q_avail),
    .pop_rec (pop_rec)
  );

  mfp_back #(
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .avail             (q_avail),
    .rec               (pop_rec),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .frame_status      (out_frame_status),
    .frame_address     (out_frame_address),
    .frame_type        (out_frame_type),
    .frame_value       (out_frame_value),
    .motor_one_position(out_motor_one_position),
    .motor_one_speed   (out_motor_one_speed),
    .motor_two_position(out_motor_two_position),
    .motor_two_speed   (out_motor_two_speed),
    .headers_seen      (out_headers_seen),
    .tail_errors       (out_tail_errors),
    .check_errors      (out_check_errors),
    .good_frames       (out_good_frames)
  );

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for motor_feedback_frame_parser: queue-fed byte driver, result monitor.
// Depends on mfp_pkg and the design files; an internal frame predictor supplies expected reports.
// Covers directed and random frames, register settings and back-pressure on both channels.
module tb_top;

  // Event counter and motor slot indexes of the predictor
  localparam logic [1:0] CNT_HEADER = 2'd0;
  localparam logic [1:0] CNT_TAIL   = 2'd1;
  localparam logic [1:0] CNT_CHECK  = 2'd2;
  localparam logic [1:0] CNT_GOOD   = 2'd3;
  localparam logic [1:0] MOTOR_ONE_POS = 2'd0;
  localparam logic [1:0] MOTOR_ONE_SPD = 2'd1;
  localparam logic [1:0] MOTOR_TWO_POS = 2'd2;
  localparam logic [1:0] MOTOR_TWO_SPD = 2'd3;

  // Register indexes past the defined four; writes there must be ignored
  localparam logic [mfp_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_LO = mfp_pkg::CFG_SPEED_TYPE + 1'b1;
  localparam logic [mfp_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_HI = '1;

  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 8;    // front end may still hold a partial frame
  localparam int DRAIN_CYCLES   = 20;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    mfp_pkg::frame_status_t status;
    logic [7:0]    addr;
    logic [7:0]    ftype;
    logic [31:0]   value;
    logic [31:0]   one_pos;
    logic [31:0]   one_spd;
    logic [31:0]   two_pos;
    logic [31:0]   two_spd;
    logic [31:0]   headers;
    logic [31:0]   tail_errs;
    logic [31:0]   check_errs;
    logic [31:0]   good;
  } feedback_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [mfp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [7:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_frame_status;
  logic [7:0]  out_frame_address;
  logic [7:0]  out_frame_type;
  logic signed [31:0] out_frame_value;
  logic signed [31:0] out_motor_one_position;
  logic signed [31:0] out_motor_one_speed;
  logic signed [31:0] out_motor_two_position;
  logic signed [31:0] out_motor_two_speed;
  logic [31:0] out_headers_seen;
  logic [31:0] out_tail_errors;
  logic [31:0] out_check_errors;
  logic [31:0] out_good_frames;

  motor_feedback_frame_parser u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_rx_byte             (in_rx_byte),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_frame_status       (out_frame_status),
    .out_frame_address      (out_frame_address),
    .out_frame_type         (out_frame_type),
    .out_frame_value        (out_frame_value),
    .out_motor_one_position (out_motor_one_position),
    .out_motor_one_speed    (out_motor_one_speed),
    .out_motor_two_position (out_motor_two_position),
    .out_motor_two_speed    (out_motor_two_speed),
    .out_headers_seen       (out_headers_seen),
    .out_tail_errors        (out_tail_errors),
    .out_check_errors       (out_check_errors),
    .out_good_frames        (out_good_frames)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Frame predictor: its own copy of the parser state and of the registers
  // ---------------------------------------------------------------------------
  logic [7:0]       cfg_first   = 8'd1;
  logic [7:0]       cfg_second  = 8'd2;
  logic [7:0]       cfg_angle   = 8'd1;
  logic [7:0]       cfg_speed   = 8'd0;
  logic [mfp_pkg::POS_W-1:0] frame_pos = mfp_pkg::POS_IDLE;
  logic [7:0]       frame_buf [8];
  logic [7:0]       bcc_acc     = '0;
  logic [31:0]      motor_val [4];
  logic [31:0]      event_cnt [4];

  feedback_report_t expected_reports [$];
  feedback_report_t oldest_report;
  logic [7:0]       byte_q [$];

  int  mismatches      = 0;
  int  reports_checked = 0;
  int  bytes_taken     = 0;
  int  cfg_writes      = 0;
  int  quiet_cycles    = 0;
  bit  run_done        = 1'b0;
  bit  byte_taken      = 1'b0;
  bit  in_calm         = 1'b0;
  bit  out_calm        = 1'b0;
  int  send_wait       = 0;
  int  hold_left       = 0;
  int  run_left        = 0;
  int  long_holds_wanted = 0;
  int  long_holds_done   = 0;

  // Advance the predictor by one accepted byte; queue a report when a frame ends.
  function automatic void parse_rx_byte(input logic [7:0] b);
    feedback_report_t rep;
    logic [7:0]       addr;
    logic [7:0]       ftype;
    logic [31:0]      value;
    logic [1:0]       slot;
    bit               slot_hit;
    slot     = MOTOR_ONE_POS;
    slot_hit = 1'b0;
    // Outside a frame: drop everything but the header
    if (frame_pos == mfp_pkg::POS_IDLE || frame_pos > mfp_pkg::POS_TAIL) begin
      if (b == mfp_pkg::HEADER_BYTE) begin
        event_cnt[CNT_HEADER]++;
        bcc_acc   = mfp_pkg::HEADER_BYTE;
        frame_pos = mfp_pkg::POS_ADDR;
      end else begin
        frame_pos = mfp_pkg::POS_IDLE;
      end
      return;
    end
    // Inside a frame every byte is data, a header byte included
    frame_buf[3'(frame_pos - mfp_pkg::POS_ADDR)] = b;
    if (frame_pos < mfp_pkg::XOR_LEN) bcc_acc ^= b;
    if (frame_pos != mfp_pkg::POS_TAIL) begin
      frame_pos++;
      return;
    end
    frame_pos = mfp_pkg::POS_IDLE;
    addr  = frame_buf[0];
    ftype = frame_buf[3'(mfp_pkg::POS_TYPE - mfp_pkg::POS_ADDR)];
    value = {frame_buf[2], frame_buf[3], frame_buf[4], frame_buf[5]};
    // Tail is checked before the check byte
    if (frame_buf[3'(mfp_pkg::POS_TAIL - mfp_pkg::POS_ADDR)] != mfp_pkg::TAIL_BYTE) begin
      rep.status = mfp_pkg::ST_BAD_TAIL;
      event_cnt[CNT_TAIL]++;
    end else if (frame_buf[3'(mfp_pkg::POS_BCC - mfp_pkg::POS_ADDR)] != bcc_acc) begin
      rep.status = mfp_pkg::ST_BAD_CHECK;
      event_cnt[CNT_CHECK]++;
    end else begin
      rep.status = mfp_pkg::ST_GOOD;
      // Motor one wins when both addresses match; angle wins over speed
      if (addr == cfg_first) begin
        if (ftype == cfg_angle) begin
          slot = MOTOR_ONE_POS;
          slot_hit = 1'b1;
        end else if (ftype == cfg_speed) begin
          slot = MOTOR_ONE_SPD;
          slot_hit = 1'b1;
        end
      end else if (addr == cfg_second) begin
        if (ftype == cfg_angle) begin
          slot = MOTOR_TWO_POS;
          slot_hit = 1'b1;
        end else if (ftype == cfg_speed) begin
          slot = MOTOR_TWO_SPD;
          slot_hit = 1'b1;
        end
      end
      if (slot_hit) motor_val[slot] = value;
      event_cnt[CNT_GOOD]++;
    end
    rep.addr       = addr;
    rep.ftype      = ftype;
    rep.value      = value;
    rep.one_pos    = motor_val[MOTOR_ONE_POS];
    rep.one_spd    = motor_val[MOTOR_ONE_SPD];
    rep.two_pos    = motor_val[MOTOR_TWO_POS];
    rep.two_spd    = motor_val[MOTOR_TWO_SPD];
    rep.headers    = event_cnt[CNT_HEADER];
    rep.tail_errs  = event_cnt[CNT_TAIL];
    rep.check_errs = event_cnt[CNT_CHECK];
    rep.good       = event_cnt[CNT_GOOD];
    expected_reports.push_back(rep);
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %08h, actual %08h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // Mostly short gaps, a few long ones; none at all in calm stretches
  function automatic int pick_gap(input bit calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Byte driver: drive at the falling edge, advance only after a transfer
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && (!in_valid || byte_taken)) begin
      if (send_wait != 0) begin
        send_wait--;
        in_valid <= 1'b0;
      end else if (byte_q.size() != 0) begin
        in_rx_byte <= byte_q.pop_front();
        in_valid   <= 1'b1;
        send_wait  = pick_gap(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stall bursts, plus the long hold when one is requested
  always @(negedge clk) begin
    if (hold_left == 0 && long_holds_done < long_holds_wanted) begin
      long_holds_done++;
      hold_left = LONG_HOLD;
    end else if (hold_left == 0 && run_left == 0) begin
      hold_left = pick_gap(out_calm);
      run_left  = $urandom_range(1, 8);
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      run_left--;
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      byte_taken   <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      byte_taken <= in_valid && !in_stall;
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      // Check the result first: a byte accepted now cannot complete this result
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: result with no frame pending: status %0d, address %02h",
                   $time, out_frame_status, out_frame_address);
          mismatches++;
        end else begin
          oldest_report = expected_reports.pop_front();
          check_field("frame_status", 32'(oldest_report.status), 32'(out_frame_status));
          check_field("frame_address", 32'(oldest_report.addr), 32'(out_frame_address));
          check_field("frame_type", 32'(oldest_report.ftype), 32'(out_frame_type));
          check_field("frame_value", oldest_report.value, out_frame_value);
          check_field("motor_one_position", oldest_report.one_pos, out_motor_one_position);
          check_field("motor_one_speed", oldest_report.one_spd, out_motor_one_speed);
          check_field("motor_two_position", oldest_report.two_pos, out_motor_two_position);
          check_field("motor_two_speed", oldest_report.two_spd, out_motor_two_speed);
          check_field("headers_seen", oldest_report.headers, out_headers_seen);
          check_field("tail_errors", oldest_report.tail_errs, out_tail_errors);
          check_field("check_errors", oldest_report.check_errs, out_check_errors);
          check_field("good_frames", oldest_report.good, out_good_frames);
          reports_checked++;
        end
      end
      if (in_valid && !in_stall) begin
        bytes_taken++;
        parse_rx_byte(in_rx_byte);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    while (!run_done && quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    if (!run_done) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic wait_idle();
    while (byte_q.size() != 0 || in_valid || expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register and mirror it in the predictor at the same edge
  task automatic write_reg(input logic [mfp_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [7:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      mfp_pkg::CFG_FIRST_ADDR:  cfg_first  = data;
      mfp_pkg::CFG_SECOND_ADDR: cfg_second = data;
      mfp_pkg::CFG_ANGLE_TYPE:  cfg_angle  = data;
      mfp_pkg::CFG_SPEED_TYPE:  cfg_speed  = data;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input logic [7:0] first, input logic [7:0] second,
                           input logic [7:0] angle, input logic [7:0] speed);
    write_reg(mfp_pkg::CFG_FIRST_ADDR, first);
    write_reg(mfp_pkg::CFG_SECOND_ADDR, second);
    write_reg(mfp_pkg::CFG_ANGLE_TYPE, angle);
    write_reg(mfp_pkg::CFG_SPEED_TYPE, speed);
  endtask

  // Queue one nine-byte frame, optionally with a bad tail or a bad check byte
  task automatic queue_frame(input logic [7:0] addr, input logic [7:0] ftype,
                             input logic [31:0] value, input mfp_pkg::frame_status_t flaw);
    logic [7:0] bcc;
    logic [7:0] tail;
    bcc  = mfp_pkg::HEADER_BYTE ^ addr ^ ftype ^ value[31:24] ^ value[23:16] ^ value[15:8] ^
           value[7:0];
    tail = mfp_pkg::TAIL_BYTE;
    if (flaw == mfp_pkg::ST_BAD_TAIL) begin
      tail = 8'($urandom);
      if (tail == mfp_pkg::TAIL_BYTE) tail = mfp_pkg::HEADER_BYTE;
      // A wrong check byte too now and then: the tail error must win
      if ($urandom_range(0, 1) != 0) bcc = ~bcc;
    end else if (flaw == mfp_pkg::ST_BAD_CHECK) begin
      bcc ^= 8'($urandom_range(1, 255));
    end
    byte_q.push_back(mfp_pkg::HEADER_BYTE);
    byte_q.push_back(addr);
    byte_q.push_back(ftype);
    byte_q.push_back(value[31:24]);
    byte_q.push_back(value[23:16]);
    byte_q.push_back(value[15:8]);
    byte_q.push_back(value[7:0]);
    byte_q.push_back(bcc);
    byte_q.push_back(tail);
  endtask

  // Random frame aimed mostly at the configured addresses and types
  task automatic queue_random_frame();
    logic [7:0]    addr;
    logic [7:0]    ftype;
    logic [31:0]   value;
    int            roll;
    mfp_pkg::frame_status_t flaw;
    roll = $urandom_range(0, 9);
    if (roll < 4) addr = cfg_first;
    else if (roll < 7) addr = cfg_second;
    else addr = 8'($urandom);
    roll = $urandom_range(0, 9);
    if (roll < 4) ftype = cfg_angle;
    else if (roll < 7) ftype = cfg_speed;
    else ftype = 8'($urandom);
    case ($urandom_range(0, 9))
      0:       value = 32'h8000_0000;
      1:       value = 32'h7FFF_FFFF;
      2:       value = '1;
      3:       value = '0;
      default: value = $urandom;
    endcase
    roll = $urandom_range(0, 99);
    if (roll < 70) flaw = mfp_pkg::ST_GOOD;
    else if (roll < 85) flaw = mfp_pkg::ST_BAD_TAIL;
    else flaw = mfp_pkg::ST_BAD_CHECK;
    queue_frame(addr, ftype, value, flaw);
  endtask

  // Mostly whole frames; some line noise and some frames cut short
  task automatic queue_traffic(input int count);
    int k;
    int kind;
    for (k = 0; k < count; k++) begin
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        queue_random_frame();
      end else if (kind == 8) begin
        repeat ($urandom_range(1, 3)) byte_q.push_back(8'($urandom));
      end else begin
        byte_q.push_back(mfp_pkg::HEADER_BYTE);
        repeat ($urandom_range(1, 7)) byte_q.push_back(8'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    motor_val = '{default: '0};
    event_cnt = '{default: '0};
    // Hold reset, then release it at a falling edge
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Directed frames under the reset register values
    byte_q.push_back(8'h00);
    byte_q.push_back(8'hFF);
    queue_frame(8'h01, 8'h01, 32'h8000_0000, mfp_pkg::ST_GOOD);
    queue_frame(8'h01, 8'h00, 32'h7FFF_FFFF, mfp_pkg::ST_GOOD);
    queue_frame(8'h02, 8'h01, 32'hFFFF_FFFF, mfp_pkg::ST_GOOD);
    queue_frame(8'h01, 8'h01, 32'h1234_5678, mfp_pkg::ST_BAD_TAIL);
    queue_frame(8'h02, 8'h00, 32'h8765_4321, mfp_pkg::ST_BAD_CHECK);
    // Unknown address, with header and tail bytes inside the value
    queue_frame(8'hFF, 8'hFF, 32'h7A7B_7A7B, mfp_pkg::ST_GOOD);
    // Known address, unknown type (a header byte as type)
    queue_frame(8'h01, mfp_pkg::HEADER_BYTE, 32'h0000_0000, mfp_pkg::ST_GOOD);
    wait_idle();

    // Extreme register values
    write_all(8'h00, 8'hFF, 8'hFF, 8'h00);
    queue_traffic(14);
    wait_idle();

    // Both addresses and both types equal; dead indexes must do nothing.
    // Send at full rate while the receiver holds off so the block fills up.
    write_all(8'h55, 8'h55, 8'hAA, 8'hAA);
    write_reg(CFG_UNUSED_LO, 8'hFF);
    write_reg(CFG_UNUSED_HI, 8'h00);
    write_reg(4'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)), 8'($urandom));
    in_calm = 1'b1;
    long_holds_wanted = 1;
    queue_traffic(16);
    wait_idle();

    // Random registers, no idling on either side
    write_all(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    out_calm = 1'b1;
    queue_traffic(14);
    wait_idle();

    // Back to the reset values with random gaps again
    in_calm  = 1'b0;
    out_calm = 1'b0;
    write_all(8'h01, 8'h02, 8'h01, 8'h00);
    queue_traffic(14);

    // Drain: all bytes sent, every report back, then a quiet tail
    while (byte_q.size() != 0 || in_valid) @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    run_done = 1'b1;

    $display("Checked %0d frame reports from %0d bytes: %0d good, %0d bad tail, %0d bad check.",
             reports_checked, bytes_taken, event_cnt[CNT_GOOD], event_cnt[CNT_TAIL],
             event_cnt[CNT_CHECK]);
    $display("Made %0d register writes over five settings, %0d long output hold(s).",
             cfg_writes, long_holds_done);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
